// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the checker file kts_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising clock edge, also while reset is applied.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/kts_pkg.sv =====
`timescale 1ns / 1ps
package kts_pkg;

	localparam int NUM_COMP = 9;
	localparam logic [3:0] FRAME_COMP = 4'd9;

	localparam logic [2:0] REG_FPS        = 3'd0;
	localparam logic [2:0] REG_CLIP_LEN   = 3'd1;
	localparam logic [2:0] REG_SPEED      = 3'd2;
	localparam logic [2:0] REG_OFFSET     = 3'd3;
	localparam logic [2:0] REG_LOOP       = 3'd4;
	localparam logic [2:0] REG_KEY_COUNT  = 3'd5;

	localparam logic [7:0]  RST_FPS       = 8'd30;
	localparam logic [15:0] RST_CLIP_LEN  = 16'd1;
	localparam logic [23:0] RST_SPEED     = 24'd65536;
	localparam logic [16:0] RST_OFFSET    = 17'd0;
	localparam logic        RST_LOOP      = 1'b0;
	localparam logic [6:0]  RST_KEY_COUNT = 7'd1;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef struct packed {
		logic [7:0]  fps;
		logic [15:0] clip_len;
		logic [23:0] speed;
		logic [16:0] offset;
		logic        loop_en;
		logic [6:0]  key_count;
	} cfg_t;

	typedef struct packed {
		logic        is_sample;
		logic        is_frame;
		logic [5:0]  key_index;
		logic [3:0]  component;
		logic [31:0] value;
		logic [31:0] frame;
	} req_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL1,
		F_MUL2,
		F_SUM,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_WALK,
		B_DSET,
		B_DIV,
		B_LRD,
		B_LMUL,
		B_LACC,
		B_OUT
	} back_state_t;

endpackage

// ===== rtl/kts_front.sv =====
`timescale 1ns / 1ps
module kts_front #(
	parameter int MAX_KEYS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic [5:0]         key_index,
	input  logic [3:0]         component,
	input  logic signed [31:0] load_value,
	input  logic [31:0]        state_time,
	input  kts_pkg::cfg_t      cfg,
	input  logic               q_full,
	output logic               push,
	output kts_pkg::req_t      push_req
);

	kts_pkg::front_state_t state_q, state_nx;
	kts_pkg::req_t req_q;
	logic [31:0] time_q;
	logic [55:0] p1_q;
	logic [63:0] p2_q;
	logic [32:0] offlen_q;
	logic [48:0] raw_q;
	logic [31:0] end_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;

	logic        load_ok;
	logic [16:0] off_sat;
	logic [15:0] len_sat;
	logic [31:0] end_c;
	logic [48:0] raw_sum;
	logic [32:0] mod_r;
	logic [31:0] rem_nx;

	assign load_ok = (32'(key_index) < MAX_KEYS) && (component <= kts_pkg::FRAME_COMP);
	assign off_sat = (cfg.offset > kts_pkg::ONE_Q16) ? kts_pkg::ONE_Q16 : cfg.offset;
	assign len_sat = (cfg.clip_len == 16'd0) ? 16'd1 : cfg.clip_len;
	assign end_c   = {len_sat, 16'h0000};
	assign raw_sum = 49'(p2_q[63:16]) + 49'(offlen_q);
	assign mod_r   = {rem_q, raw_q[48]};
	assign rem_nx  = (mod_r >= {1'b0, end_q}) ? 32'(mod_r - {1'b0, end_q}) : mod_r[31:0];

	always_comb begin
		state_nx = state_q;
		case (state_q)
			kts_pkg::F_IDLE: begin
				if (start) begin
					if (mode) begin
						state_nx = kts_pkg::F_MUL1;
					end else if (load_ok) begin
						state_nx = kts_pkg::F_PUSH;
					end
				end
			end
			kts_pkg::F_MUL1: state_nx = kts_pkg::F_MUL2;
			kts_pkg::F_MUL2: state_nx = kts_pkg::F_SUM;
			kts_pkg::F_SUM:  state_nx = cfg.loop_en ? kts_pkg::F_MOD : kts_pkg::F_PUSH;
			kts_pkg::F_MOD: begin
				if (cnt_q == 6'd0) begin
					state_nx = kts_pkg::F_PUSH;
				end
			end
			kts_pkg::F_PUSH: begin
				if (!q_full) begin
					state_nx = kts_pkg::F_IDLE;
				end
			end
			default: state_nx = kts_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != kts_pkg::F_IDLE);
		push = (state_q == kts_pkg::F_PUSH) && !q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kts_pkg::F_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			kts_pkg::F_IDLE: begin
				req_q.is_sample <= mode;
				req_q.is_frame  <= (component == kts_pkg::FRAME_COMP);
				req_q.key_index <= key_index;
				req_q.component <= component;
				req_q.frame     <= 32'd0;
				if (component == kts_pkg::FRAME_COMP) begin
					if (load_value < 0) begin
						req_q.value <= 32'd0;
					end else if (load_value > 32'sd65535) begin
						req_q.value <= 32'd65535;
					end else begin
						req_q.value <= load_value;
					end
				end else begin
					req_q.value <= load_value;
				end
				time_q <= state_time;
			end
			kts_pkg::F_MUL1: begin
				p1_q <= 56'(time_q) * 56'(cfg.speed);
			end
			kts_pkg::F_MUL2: begin
				p2_q     <= 64'(p1_q) * 64'(cfg.fps);
				offlen_q <= 33'(off_sat) * 33'(len_sat);
			end
			kts_pkg::F_SUM: begin
				raw_q <= raw_sum;
				end_q <= end_c;
				rem_q <= 32'd0;
				cnt_q <= 6'd48;
				req_q.frame <= (raw_sum < 49'(end_c)) ? raw_sum[31:0] : end_c;
			end
			kts_pkg::F_MOD: begin
				rem_q <= rem_nx;
				raw_q <= {raw_q[47:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					req_q.frame <= rem_nx;
				end
			end
			default: begin
			end
		endcase
	end

	assign push_req = req_q;

endmodule

// ===== rtl/kts_queue.sv =====
`timescale 1ns / 1ps
module kts_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kts_pkg::req_t push_req,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output kts_pkg::req_t pop_req
);

	kts_pkg::req_t entry_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign pop_req = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_req;
		end
	end

endmodule

// ===== rtl/kts_back.sv =====
`timescale 1ns / 1ps
module kts_back #(
	parameter int MAX_KEYS    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  kts_pkg::req_t      pop_req,
	output logic               pop,
	input  logic [6:0]         key_count,
	output logic               done,
	output logic [8:0][31:0]   values,
	output logic [31:0]        frame
);

	localparam int KW    = $clog2(MAX_KEYS);
	localparam int CW    = $clog2(MAX_KEYS + 1);
	localparam int DEPTH = MAX_KEYS * kts_pkg::NUM_COMP;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam int IXW   = KW + 6;

	logic [15:0]   kf_mem [MAX_KEYS];
	logic [SW-1:0] kv_mem [DEPTH];

	kts_pkg::back_state_t state_q, state_nx;

	logic [CW-1:0] n_keys;
	logic [CW-1:0] rd_idx_q;
	logic          chk_vld_s1;
	logic [CW-1:0] chk_idx_s1;
	logic [15:0]   kf_s1;
	logic [CW-1:0] prev_q, next_q;
	logic [15:0]   pf_q, nf_q;
	logic [31:0]   frame_q;

	logic [31:0] dq_q;
	logic [15:0] drem_q;
	logic [15:0] dden_q;
	logic [4:0]  dcnt_q;
	logic [16:0] t_q;
	logic [3:0]  c_q;

	logic [SW-1:0]      a_rd_q, b_rd_q;
	logic signed [32:0] a_s2;
	logic signed [50:0] prod_s2;
	logic [8:0][31:0]   res_q;

	logic [IXW-1:0] idx_wide;
	logic [KW-1:0]  kf_waddr;
	logic [AW-1:0]  kv_waddr, a_addr, b_addr;
	logic           ld_we;
	logic           rd_en, kf_le, kf_ge, is_last, walk_done;
	logic [32:0]    num_s;
	logic [16:0]    den_s;
	logic           div_ok;
	logic [16:0]    div_r;
	logic           div_ge;
	logic [31:0]    quo;
	logic signed [32:0] a_ext, b_ext, diff;
	logic signed [50:0] prod, acc;

	always_comb begin
		if (key_count == 7'd0) begin
			n_keys = CW'(1);
		end else if (32'(key_count) > MAX_KEYS) begin
			n_keys = CW'(MAX_KEYS);
		end else begin
			n_keys = CW'(key_count);
		end
	end

	assign pop      = (state_q == kts_pkg::B_IDLE) && !empty;
	assign ld_we    = pop && !pop_req.is_sample;
	assign idx_wide = IXW'(pop_req.key_index);
	assign kf_waddr = idx_wide[KW-1:0];
	assign kv_waddr = AW'(kf_waddr) * AW'(kts_pkg::NUM_COMP) + AW'(pop_req.component);
	assign a_addr   = AW'(prev_q) * AW'(kts_pkg::NUM_COMP) + AW'(c_q);
	assign b_addr   = AW'(next_q) * AW'(kts_pkg::NUM_COMP) + AW'(c_q);

	assign rd_en     = (rd_idx_q < n_keys);
	assign kf_le     = ({kf_s1, 16'h0000} <= frame_q);
	assign kf_ge     = ({kf_s1, 16'h0000} >= frame_q);
	assign is_last   = (chk_idx_s1 == n_keys - CW'(1));
	assign walk_done = chk_vld_s1 && (kf_ge || is_last);

	assign num_s  = {1'b0, frame_q} - {1'b0, pf_q, 16'h0000};
	assign den_s  = {1'b0, nf_q} - {1'b0, pf_q};
	assign div_ok = !num_s[32] && (num_s != 33'd0) && !den_s[16] && (den_s != 17'd0);
	assign div_r  = {drem_q, dq_q[31]};
	assign div_ge = (div_r >= {1'b0, dden_q});
	assign quo    = {dq_q[30:0], div_ge};

	assign a_ext = 33'($signed(a_rd_q));
	assign b_ext = 33'($signed(b_rd_q));
	assign diff  = b_ext - a_ext;
	assign prod  = 51'(diff) * 51'($signed({1'b0, t_q}));
	assign acc   = 51'(a_s2) + (prod_s2 >>> 16);

	always_ff @(posedge clk) begin
		if (ld_we && pop_req.is_frame) begin
			kf_mem[kf_waddr] <= pop_req.value[15:0];
		end
		kf_s1 <= kf_mem[rd_idx_q[KW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ld_we && !pop_req.is_frame) begin
			kv_mem[kv_waddr] <= pop_req.value[SW-1:0];
		end
		a_rd_q <= kv_mem[a_addr];
		b_rd_q <= kv_mem[b_addr];
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			kts_pkg::B_IDLE: begin
				if (pop && pop_req.is_sample) begin
					state_nx = kts_pkg::B_WALK;
				end
			end
			kts_pkg::B_WALK: begin
				if (walk_done) begin
					state_nx = kts_pkg::B_DSET;
				end
			end
			kts_pkg::B_DSET: state_nx = div_ok ? kts_pkg::B_DIV : kts_pkg::B_LRD;
			kts_pkg::B_DIV: begin
				if (dcnt_q == 5'd0) begin
					state_nx = kts_pkg::B_LRD;
				end
			end
			kts_pkg::B_LRD:  state_nx = kts_pkg::B_LMUL;
			kts_pkg::B_LMUL: state_nx = kts_pkg::B_LACC;
			kts_pkg::B_LACC: begin
				state_nx = (c_q == 4'(kts_pkg::NUM_COMP - 1)) ? kts_pkg::B_OUT
									       : kts_pkg::B_LRD;
			end
			kts_pkg::B_OUT: state_nx = kts_pkg::B_IDLE;
			default:        state_nx = kts_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		done   = (state_q == kts_pkg::B_OUT);
		values = res_q;
		frame  = frame_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kts_pkg::B_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			kts_pkg::B_IDLE: begin
				rd_idx_q   <= '0;
				chk_vld_s1 <= 1'b0;
				chk_idx_s1 <= '0;
				frame_q    <= pop_req.frame;
			end
			kts_pkg::B_WALK: begin
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				chk_vld_s1 <= rd_en;
				chk_idx_s1 <= rd_idx_q;
				if (chk_vld_s1) begin
					if (kf_le || chk_idx_s1 == '0) begin
						prev_q <= chk_idx_s1;
						pf_q   <= kf_s1;
					end
					if (kf_ge || is_last) begin
						next_q <= chk_idx_s1;
						nf_q   <= kf_s1;
					end
				end
			end
			kts_pkg::B_DSET: begin
				dq_q   <= num_s[31:0];
				drem_q <= 16'd0;
				dden_q <= den_s[15:0];
				dcnt_q <= 5'd31;
				t_q    <= 17'd0;
				c_q    <= 4'd0;
			end
			kts_pkg::B_DIV: begin
				drem_q <= div_ge ? 16'(div_r - {1'b0, dden_q}) : div_r[15:0];
				dq_q   <= quo;
				dcnt_q <= dcnt_q - 5'd1;
				if (dcnt_q == 5'd0) begin
					t_q <= (quo > 32'(kts_pkg::ONE_Q16)) ? kts_pkg::ONE_Q16 : quo[16:0];
				end
			end
			kts_pkg::B_LMUL: begin
				a_s2    <= a_ext;
				prod_s2 <= prod;
			end
			kts_pkg::B_LACC: begin
				res_q[c_q] <= acc[31:0];
				c_q        <= c_q + 4'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/keyframe_transform_sampler.sv =====
`timescale 1ns / 1ps
// Keyframe transform sampler.
// Requests enter on start while busy is low. mode 0 loads one component of a key
// (nine Q16.16 values or the integer frame number); mode 1 samples the clip at
// state_time. Loads give no result. Each sample gives one result on the result
// ports, valid for the single cycle in which done is high; the receiver cannot stall.
// The front turns a time into a frame position, clamping it to the clip end or,
// when looping, wrapping it with a 49-step serial remainder.
// A two-entry queue decouples the front from the back, so busy drops once the
// front has handed the request on.
// The back walks the key frame memory one key per cycle, runs a 32-step serial
// divide for the weight (a zero weight without the divide when the frame offset
// or the key span is not positive), then interpolates the nine components one at
// a time with one multiplier, each through read, multiply and accumulate states.
// A sample's result also waits while the back still works on earlier requests.
// Reset clears the control state and the configuration registers. Key memories
// hold no reset value and must be loaded before they are sampled.
module keyframe_transform_sampler #(
	parameter int MAX_KEYS    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic [5:0]         key_index,
	input  logic [3:0]         component,
	input  logic signed [31:0] load_value,
	input  logic [31:0]        state_time,
	output logic               done,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [31:0] rot_x,
	output logic signed [31:0] rot_y,
	output logic signed [31:0] rot_z,
	output logic signed [31:0] scale_x,
	output logic signed [31:0] scale_y,
	output logic signed [31:0] scale_z,
	output logic [31:0]        frame_position
);

	kts_pkg::cfg_t cfg_q;
	kts_pkg::req_t push_req, pop_req;
	logic          push, pop, q_full, q_empty;
	logic [8:0][31:0] values;
	logic          cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fps       <= kts_pkg::RST_FPS;
			cfg_q.clip_len  <= kts_pkg::RST_CLIP_LEN;
			cfg_q.speed     <= kts_pkg::RST_SPEED;
			cfg_q.offset    <= kts_pkg::RST_OFFSET;
			cfg_q.loop_en   <= kts_pkg::RST_LOOP;
			cfg_q.key_count <= kts_pkg::RST_KEY_COUNT;
		end else if (cfg_we) begin
			case (paddr[4:2])
				kts_pkg::REG_FPS:       cfg_q.fps       <= pwdata[7:0];
				kts_pkg::REG_CLIP_LEN:  cfg_q.clip_len  <= pwdata[15:0];
				kts_pkg::REG_SPEED:     cfg_q.speed     <= pwdata[23:0];
				kts_pkg::REG_OFFSET:    cfg_q.offset    <= pwdata[16:0];
				kts_pkg::REG_LOOP:      cfg_q.loop_en   <= pwdata[0];
				kts_pkg::REG_KEY_COUNT: cfg_q.key_count <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			kts_pkg::REG_FPS:       prdata = 32'(cfg_q.fps);
			kts_pkg::REG_CLIP_LEN:  prdata = 32'(cfg_q.clip_len);
			kts_pkg::REG_SPEED:     prdata = 32'(cfg_q.speed);
			kts_pkg::REG_OFFSET:    prdata = 32'(cfg_q.offset);
			kts_pkg::REG_LOOP:      prdata = 32'(cfg_q.loop_en);
			kts_pkg::REG_KEY_COUNT: prdata = 32'(cfg_q.key_count);
			default:                prdata = 32'd0;
		endcase
	end

	kts_front #(
		.MAX_KEYS(MAX_KEYS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.key_index (key_index),
		.component (component),
		.load_value(load_value),
		.state_time(state_time),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push),
		.push_req  (push_req)
	);

	kts_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_req(push_req),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.pop_req (pop_req)
	);

	kts_back #(
		.MAX_KEYS   (MAX_KEYS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.pop_req  (pop_req),
		.pop      (pop),
		.key_count(cfg_q.key_count),
		.done     (done),
		.values   (values),
		.frame    (frame_position)
	);

	assign pos_x   = values[0];
	assign pos_y   = values[1];
	assign pos_z   = values[2];
	assign rot_x   = values[3];
	assign rot_y   = values[4];
	assign rot_z   = values[5];
	assign scale_x = values[6];
	assign scale_y = values[7];
	assign scale_z = values[8];

endmodule

// ===== rtl/kts_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kts_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic mode,
	input logic done,
	input logic psel,
	input logic penable,
	input logic pready
);

	// A sample request taken while idle raises busy.
	`ASSERT_CLK(a_sample_busy, start && !busy && mode |=> busy, "sample request did not raise busy")

	// Two results can never come out in adjacent cycles.
	`ASSERT_CLK(a_done_pulse, done |=> !done, "result strobe held longer than one cycle")

	`ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !done && !busy, "activity during reset")

	`ASSERT_CLK(a_apb_ready, psel && penable |-> pready, "configuration access stalled")

endmodule

bind keyframe_transform_sampler kts_checker u_kts_checker (.*);

// ===== bench/keyframe_transform_sampler_checker.sv =====
`timescale 1ns / 1ps
module keyframe_transform_sampler_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               start,
	input  logic               busy,
	input  logic               mode,
	input  logic [5:0]         key_index,
	input  logic [3:0]         component,
	input  logic signed [31:0] load_value,
	input  logic [31:0]        state_time,
	input  logic               done,
	input  logic [9:0][31:0]   result,
	output int                 errors,
	output int                 outstanding
);

	typedef logic [9:0][31:0] sample_t;

	localparam int KEYS = 64;

	logic [7:0]  fps;
	logic [15:0] clip_len;
	logic [23:0] speed;
	logic [16:0] offset;
	logic        loop_en;
	logic [6:0]  key_count;

	logic [15:0]        key_frame [KEYS];
	logic signed [31:0] key_value [KEYS][kts_pkg::NUM_COMP];

	sample_t expected_samples [$];
	string   field_names [10] = '{"pos_x", "pos_y", "pos_z", "rot_x", "rot_y", "rot_z",
		"scale_x", "scale_y", "scale_z", "frame_position"};

	assign outstanding = expected_samples.size();

	function automatic sample_t interpolate_sample(logic [31:0] tm);
		longint unsigned len, off, raw, clip_end, frame;
		int              n, prev, nxt;
		longint          pf, nf, t, num, den, a, b, p;
		sample_t         r;
		len = (clip_len == 0) ? 64'd1 : 64'(clip_len);
		off = (offset > kts_pkg::ONE_Q16) ? 64'd65536 : 64'(offset);
		raw = ((64'(tm) * 64'(speed) * 64'(fps)) >> 16) + off * len;
		clip_end = len << 16;
		if (loop_en) begin
			frame = raw % clip_end;
		end else begin
			frame = (raw < clip_end) ? raw : clip_end;
		end
		n = key_count;
		if (n < 1) n = 1;
		if (n > KEYS) n = KEYS;
		prev = 0;
		nxt = n - 1;
		for (int i = 0; i < n; i++) begin
			if ((64'(key_frame[i]) << 16) <= frame) prev = i;
			if ((64'(key_frame[i]) << 16) >= frame) begin
				nxt = i;
				break;
			end
		end
		pf = key_frame[prev];
		nf = key_frame[nxt];
		t = 0;
		if (nf != pf) begin
			num = longint'(frame) - pf * 65536;
			den = nf - pf;
			if (num > 0 && den > 0) begin
				t = num / den;
				if (t > 65536) t = 65536;
			end
		end
		for (int i = 0; i < kts_pkg::NUM_COMP; i++) begin
			a = key_value[prev][i];
			b = key_value[nxt][i];
			p = (b - a) * t;
			r[i] = 32'(a + (p >>> 16));
		end
		r[9] = frame[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fps       <= kts_pkg::RST_FPS;
			clip_len  <= kts_pkg::RST_CLIP_LEN;
			speed     <= kts_pkg::RST_SPEED;
			offset    <= kts_pkg::RST_OFFSET;
			loop_en   <= kts_pkg::RST_LOOP;
			key_count <= kts_pkg::RST_KEY_COUNT;
			errors    = 0;
			expected_samples.delete();
			for (int i = 0; i < KEYS; i++) begin
				key_frame[i] = '0;
				for (int c = 0; c < kts_pkg::NUM_COMP; c++) key_value[i][c] = '0;
			end
		end else begin
			if (done) begin
				if (expected_samples.size() == 0) begin
					errors++;
					$display("%0t: result with no request waiting, frame_position %h",
						$time, result[9]);
				end else begin
					sample_t want;
					want = expected_samples.pop_front();
					for (int i = 0; i < 10; i++) begin
						if (result[i] !== want[i]) begin
							errors++;
							$display("%0t: %s expected %h actual %h", $time,
								field_names[i], want[i], result[i]);
						end
					end
				end
			end
			if (start && !busy) begin
				if (mode) begin
					expected_samples = {expected_samples, interpolate_sample(state_time)};
				end else if (component == kts_pkg::FRAME_COMP) begin
					if (load_value < 0) key_frame[key_index] = 16'd0;
					else if (load_value > 65535) key_frame[key_index] = 16'hFFFF;
					else key_frame[key_index] = load_value[15:0];
				end else if (component < kts_pkg::FRAME_COMP) begin
					key_value[key_index][component] = load_value;
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					kts_pkg::REG_FPS: fps <= pwdata[7:0];
					kts_pkg::REG_CLIP_LEN: clip_len <= pwdata[15:0];
					kts_pkg::REG_SPEED: speed <= pwdata[23:0];
					kts_pkg::REG_OFFSET: offset <= pwdata[16:0];
					kts_pkg::REG_LOOP: loop_en <= pwdata[0];
					kts_pkg::REG_KEY_COUNT: key_count <= pwdata[6:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== bench/keyframe_transform_sampler_tb.sv =====
`timescale 1ns / 1ps
module keyframe_transform_sampler_tb;

	localparam int TOTAL_ITEMS = 1450;
	localparam int QUIET_FROM  = 1300;
	localparam int DRAIN       = 200;
	localparam int CYCLE_LIMIT = 1500000;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               pready;
	logic               start, busy, mode;
	logic [5:0]         key_index;
	logic [3:0]         component;
	logic signed [31:0] load_value;
	logic [31:0]        state_time;
	logic               done;
	logic [9:0][31:0]   result;
	int                 errors, outstanding;
	int                 items, cycles;

	logic [7:0]  cur_fps;
	logic [15:0] cur_len;
	logic [23:0] cur_speed;
	logic [6:0]  cur_count;
	logic [9:0]  written [64];

	keyframe_transform_sampler dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.start, .busy, .mode, .key_index, .component, .load_value, .state_time, .done,
		.pos_x(result[0]), .pos_y(result[1]), .pos_z(result[2]),
		.rot_x(result[3]), .rot_y(result[4]), .rot_z(result[5]),
		.scale_x(result[6]), .scale_y(result[7]), .scale_z(result[8]),
		.frame_position(result[9])
	);

	keyframe_transform_sampler_checker checker_i (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.start, .busy, .mode, .key_index, .component, .load_value, .state_time,
		.done, .result, .errors, .outstanding
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** keyframe_transform_sampler: FAILED **");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			kts_pkg::REG_FPS: cur_fps = value[7:0];
			kts_pkg::REG_CLIP_LEN: cur_len = value[15:0];
			kts_pkg::REG_SPEED: cur_speed = value[23:0];
			kts_pkg::REG_KEY_COUNT: cur_count = value[6:0];
			default: ;
		endcase
	endtask

	task automatic maybe_idle();
		if (items < QUIET_FROM && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic send_request(logic m, logic [5:0] idx, logic [3:0] comp,
			logic [31:0] value, logic [31:0] tm);
		maybe_idle();
		start      <= 1'b1;
		mode       <= m;
		key_index  <= idx;
		component  <= comp;
		load_value <= value;
		state_time <= tm;
		do @(posedge clk); while (busy);
		items++;
		if (!m && comp <= kts_pkg::FRAME_COMP) written[idx][comp] = 1'b1;
	endtask

	task automatic load_key(logic [5:0] idx, logic [3:0] comp, logic [31:0] value);
		send_request(1'b0, idx, comp, value, $urandom());
	endtask

	task automatic sample_at(logic [31:0] tm);
		send_request(1'b1, 6'($urandom()), 4'($urandom()), $urandom(), tm);
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic int keys_in_use();
		if (cur_count == 0) return 1;
		if (cur_count > 64) return 64;
		return cur_count;
	endfunction

	task automatic fill_keys(int n);
		for (int k = 0; k < n; k++)
			for (int c = 0; c <= kts_pkg::FRAME_COMP; c++)
				if (!written[k][c]) load_key(6'(k), 4'(c), $urandom());
	endtask

	// A time that lands mostly inside the clip at the current rate.
	function automatic logic [31:0] pick_time();
		longint unsigned rate, lim;
		rate = 64'(cur_speed) * 64'(cur_fps);
		if (rate == 0 || $urandom_range(0, 9) == 0) return $urandom();
		lim = ((64'(cur_len) + 2) << 32) / rate;
		if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
		return $urandom_range(0, 32'(lim));
	endfunction

	initial begin
		int phase, n, frame, span, burst;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		start = 1'b0; mode = 1'b0; key_index = '0; component = '0;
		load_value = '0; state_time = '0;
		items = 0; cycles = 0;
		cur_fps = kts_pkg::RST_FPS; cur_len = kts_pkg::RST_CLIP_LEN;
		cur_speed = kts_pkg::RST_SPEED;
		cur_count = kts_pkg::RST_KEY_COUNT;
		for (int k = 0; k < 64; k++) written[k] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: value extremes, clamped frame numbers, ignored loads.
		for (int c = 0; c < kts_pkg::NUM_COMP; c++) begin
			load_key(6'd0, 4'(c), (c % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
			load_key(6'd1, 4'(c), (c % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
		end
		load_key(6'd0, kts_pkg::FRAME_COMP, 32'hFFFF_FFFB);
		load_key(6'd1, kts_pkg::FRAME_COMP, 32'd100000);
		load_key(6'd63, 4'd10, 32'h1234_5678);
		load_key(6'd42, 4'd15, 32'hFFFF_FFFF);
		sample_at(32'd0);
		sample_at(32'hFFFF_FFFF);
		settle();
		reg_write(kts_pkg::REG_CLIP_LEN, 32'd0);
		reg_write(kts_pkg::REG_OFFSET, 32'h1_FFFF);
		reg_write(kts_pkg::REG_KEY_COUNT, 32'd0);
		sample_at(32'h0001_8000);
		settle();
		reg_write(kts_pkg::REG_CLIP_LEN, 32'hFFFF);
		reg_write(kts_pkg::REG_OFFSET, 32'd0);
		reg_write(kts_pkg::REG_KEY_COUNT, 32'd2);
		reg_write(kts_pkg::REG_SPEED, 32'hFF_FFFF);
		reg_write(kts_pkg::REG_FPS, 32'hFF);
		reg_write(kts_pkg::REG_LOOP, 32'd1);
		sample_at(32'hFFFF_FFFF);
		sample_at(32'h0000_8000);
		settle();

		phase = 0;
		while (items < TOTAL_ITEMS) begin
			phase++;
			case (phase % 6)
				0: reg_write(kts_pkg::REG_FPS, $urandom_range(0, 1) ? 32'd1 : 32'd240);
				1: reg_write(kts_pkg::REG_FPS, $urandom_range(0, 255));
				default: reg_write(kts_pkg::REG_FPS, $urandom_range(1, 240));
			endcase
			reg_write(kts_pkg::REG_CLIP_LEN, (phase % 7 == 0) ? $urandom_range(0, 65535) :
				$urandom_range(1, 400));
			reg_write(kts_pkg::REG_SPEED, (phase % 5 == 0) ? $urandom_range(0, 24'hFF_FFFF) :
				(phase % 5 == 1) ? 32'd65536 : $urandom_range(0, 24'h4_0000));
			reg_write(kts_pkg::REG_OFFSET, (phase % 4 == 0) ? $urandom_range(0, 17'h1_FFFF) :
				$urandom_range(0, 1) ? 32'd0 : 32'h1_0000);
			reg_write(kts_pkg::REG_LOOP, $urandom_range(0, 1));
			reg_write(kts_pkg::REG_KEY_COUNT, (phase % 9 == 0) ? $urandom_range(0, 127) :
				(phase % 9 == 1) ? 32'd64 : $urandom_range(1, 8));
			n = keys_in_use();
			fill_keys(n);
			// Ascending frames across the clip, sometimes repeated or in random order.
			if (n <= 16 || $urandom_range(0, 3) == 0) begin
				span = (cur_len == 0 ? 1 : cur_len);
				frame = 0;
				for (int k = 0; k < n; k++) begin
					if (phase % 8 == 3) frame = $urandom_range(0, span);
					else if ($urandom_range(0, 5) != 0)
						frame = frame + $urandom_range(0, span / n + 1);
					load_key(6'(k), kts_pkg::FRAME_COMP, 32'(frame));
				end
			end
			burst = $urandom_range(15, 40);
			for (int j = 0; j < burst && items < TOTAL_ITEMS; j++) begin
				if ($urandom_range(0, 3) == 0)
					load_key(6'($urandom_range(0, n - 1)), 4'($urandom_range(0, 15)),
						$urandom());
				else
					sample_at(pick_time());
			end
			settle();
		end

		if (errors == 0 && outstanding == 0) begin
			$display("** keyframe_transform_sampler: PASSED **");
		end else begin
			$display("** keyframe_transform_sampler: FAILED **");
		end
		$finish;
	end

endmodule
